### hdl/ctf_pkg.sv
// ----------------------------------------------------------------------------
// ctf_pkg
// Shared types, constants and helper functions of the complementary tilt
// filter: beat payloads, controller commands, the CORDIC angle table.
// ----------------------------------------------------------------------------
package ctf_pkg;

  // Number of CORDIC vectoring iterations (8 to 24).
  localparam int CORDIC_STEPS    = 16;
  // Fraction bits of the angle outputs (8 to 20).
  localparam int ANGLE_FRAC_BITS = 16;

  localparam int TABLE_FRAC      = 24;
  localparam int RATE_TIME_SHIFT = 25;
  localparam int INC_SHIFT       = RATE_TIME_SHIFT - ANGLE_FRAC_BITS;
  localparam int TILT_SHIFT      = TABLE_FRAC - ANGLE_FRAC_BITS;
  localparam int PRESCALE_SHIFT  = 14;
  // The integer square root walks its trial bit from 2^32 down to 2^0.
  localparam int ROOT_STEPS      = 17;

  localparam int TS_W  = 21;
  localparam int GW_W  = 16;
  localparam int CFG_W = 21;
  localparam int CNT_W = 5;

  // Register indexes of the configuration port.
  localparam logic REG_TIME_STEP   = 1'b0;
  localparam logic REG_GYRO_WEIGHT = 1'b1;

  localparam logic [TS_W-1:0] TIME_STEP_RESET   = 21'd1049;
  localparam logic [GW_W-1:0] GYRO_WEIGHT_RESET = 16'd62259;

  // Datapath operations issued by the controller.
  localparam logic [3:0] OP_NOP   = 4'd0;
  localparam logic [3:0] OP_LOAD  = 4'd1;
  localparam logic [3:0] OP_MUL   = 4'd2;
  localparam logic [3:0] OP_INC   = 4'd3;
  localparam logic [3:0] OP_BW    = 4'd4;
  localparam logic [3:0] OP_BT    = 4'd5;
  localparam logic [3:0] OP_BR    = 4'd6;
  localparam logic [3:0] OP_SQ1   = 4'd7;
  localparam logic [3:0] OP_SQ2   = 4'd8;
  localparam logic [3:0] OP_ROOT  = 4'd9;
  localparam logic [3:0] OP_CINIT = 4'd10;
  localparam logic [3:0] OP_CORD  = 4'd11;
  localparam logic [3:0] OP_CEND  = 4'd12;
  localparam logic [3:0] OP_OUT   = 4'd13;

  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] rate_x;
    logic signed [15:0] rate_y;
    logic signed [15:0] rate_z;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] angle_x;
    logic signed [31:0] angle_y;
    logic signed [31:0] angle_z;
  } out_item_t;

  typedef struct packed {
    logic [3:0]       op;
    logic [1:0]       sel;
    logic [CNT_W-1:0] iter;
  } cmd_t;

  // atan(2^-i) in degrees, 24 fraction bits.
  function automatic logic signed [32:0] atan_q24(input logic [CNT_W-1:0] idx);
    logic signed [32:0] v;
    unique case (idx)
      5'd0:  v = 33'sd754974720;
      5'd1:  v = 33'sd445687602;
      5'd2:  v = 33'sd235489088;
      5'd3:  v = 33'sd119537938;
      5'd4:  v = 33'sd60000934;
      5'd5:  v = 33'sd30029717;
      5'd6:  v = 33'sd15018523;
      5'd7:  v = 33'sd7509720;
      5'd8:  v = 33'sd3754917;
      5'd9:  v = 33'sd1877466;
      5'd10: v = 33'sd938734;
      5'd11: v = 33'sd469367;
      5'd12: v = 33'sd234684;
      5'd13: v = 33'sd117342;
      5'd14: v = 33'sd58671;
      5'd15: v = 33'sd29335;
      5'd16: v = 33'sd14668;
      5'd17: v = 33'sd7334;
      5'd18: v = 33'sd3667;
      5'd19: v = 33'sd1833;
      5'd20: v = 33'sd917;
      5'd21: v = 33'sd458;
      5'd22: v = 33'sd229;
      5'd23: v = 33'sd115;
      default: v = 33'sd0;
    endcase
    return v;
  endfunction

  // Clamp to the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sh000000007fffffff) begin
      r = 32'sh7fffffff;
    end else if (v < -64'sh0000000080000000) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

### hdl/complementary_tilt_filter.sv
// ----------------------------------------------------------------------------
// complementary_tilt_filter
// Fuses one IMU beat into two tilt angles and an integrated yaw angle, with a
// one-sample lag, using shared multipliers, a serial square root and CORDIC.
// ----------------------------------------------------------------------------
// A beat is taken only in the idle state, and the block finishes one beat
// before it takes the next; the two 17-step square roots and the two
// CORDIC passes of 16 iterations run one after the other on one unit.
// The next input beat is taken while a finished result still waits.
// Reset (rst, synchronous) clears all angles and rates and loads the register
// defaults: time_step 1049, gyro_weight 62259.
module complementary_tilt_filter
  import ctf_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_data
);

  // The controller drives one command per cycle into the datapath. All
  // arithmetic, state and configuration sit in the datapath; the controller
  // only counts steps and runs the handshakes.
  cmd_t cmd;

  ctf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  ctf_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .out_data  (out_data)
  );

endmodule

### hdl/ctf_ctrl.sv
// ----------------------------------------------------------------------------
// ctf_ctrl
// Sequencer of the tilt filter: walks the blend, yaw, square root and CORDIC
// steps of one sample and owns both handshakes.
// ----------------------------------------------------------------------------
module ctf_ctrl
  import ctf_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output cmd_t cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MUL   = 4'd1;
  localparam logic [3:0] S_INC   = 4'd2;
  localparam logic [3:0] S_BW    = 4'd3;
  localparam logic [3:0] S_BT    = 4'd4;
  localparam logic [3:0] S_BR    = 4'd5;
  localparam logic [3:0] S_SQ1   = 4'd6;
  localparam logic [3:0] S_SQ2   = 4'd7;
  localparam logic [3:0] S_ROOT  = 4'd8;
  localparam logic [3:0] S_CINIT = 4'd9;
  localparam logic [3:0] S_CORD  = 4'd10;
  localparam logic [3:0] S_CEND  = 4'd11;
  localparam logic [3:0] S_OUT   = 4'd12;

  logic [3:0]       state, state_next;
  logic [1:0]       sel, sel_next;
  logic [CNT_W-1:0] iter, iter_next;
  logic             out_valid_next;
  logic             out_load;

  always_comb begin
    state_next = state;
    sel_next   = sel;
    iter_next  = iter;
    in_ready   = 1'b0;
    out_load   = 1'b0;
    cmd.op     = OP_NOP;
    cmd.sel    = sel;
    cmd.iter   = iter;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          sel_next   = 2'd0;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.op     = OP_MUL;
        state_next = S_INC;
      end
      S_INC: begin
        cmd.op = OP_INC;
        if (sel == 2'd2) begin
          sel_next   = 2'd0;
          state_next = S_SQ1;
        end else begin
          state_next = S_BW;
        end
      end
      S_BW: begin
        cmd.op     = OP_BW;
        state_next = S_BT;
      end
      S_BT: begin
        cmd.op     = OP_BT;
        state_next = S_BR;
      end
      S_BR: begin
        cmd.op     = OP_BR;
        sel_next   = sel + 2'd1;
        state_next = S_MUL;
      end
      S_SQ1: begin
        cmd.op     = OP_SQ1;
        state_next = S_SQ2;
      end
      S_SQ2: begin
        cmd.op     = OP_SQ2;
        iter_next  = '0;
        state_next = S_ROOT;
      end
      S_ROOT: begin
        cmd.op = OP_ROOT;
        if (iter == CNT_W'(ROOT_STEPS - 1)) begin
          state_next = S_CINIT;
        end else begin
          iter_next = iter + 1'b1;
        end
      end
      S_CINIT: begin
        cmd.op     = OP_CINIT;
        iter_next  = '0;
        state_next = S_CORD;
      end
      S_CORD: begin
        cmd.op = OP_CORD;
        if (iter == CNT_W'(CORDIC_STEPS - 1)) begin
          state_next = S_CEND;
        end else begin
          iter_next = iter + 1'b1;
        end
      end
      S_CEND: begin
        cmd.op = OP_CEND;
        if (sel == 2'd1) begin
          state_next = S_OUT;
        end else begin
          sel_next   = 2'd1;
          state_next = S_SQ1;
        end
      end
      S_OUT: begin
        if (!out_valid || out_ready) begin
          cmd.op     = OP_OUT;
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign out_valid_next = out_load | (out_valid & ~out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      sel       <= '0;
      iter      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      sel       <= sel_next;
      iter      <= iter_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

### hdl/ctf_datapath.sv
// ----------------------------------------------------------------------------
// ctf_datapath
// Filter state, configuration registers, shared multiplier paths, the
// bit-serial square root and the CORDIC vectoring unit.
// ----------------------------------------------------------------------------
module ctf_datapath
  import ctf_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  in_item_t         in_data,
  input  cmd_t             cmd,
  output out_item_t        out_data
);

  logic [TS_W-1:0] time_step;
  logic [GW_W-1:0] gyro_weight;

  logic signed [31:0] fused [2];
  logic signed [31:0] last_tilt [2];
  logic signed [15:0] last_rate [3];
  logic signed [31:0] yaw_sum;
  in_item_t           cur;

  logic signed [37:0] prod;
  logic signed [39:0] sum;
  logic signed [56:0] pw;
  logic signed [49:0] pt;

  logic signed [31:0] sqb;
  logic [32:0]        rem;
  logic [32:0]        res;
  logic [32:0]        rbit;

  logic signed [33:0] cx, cy;
  logic signed [32:0] cz;
  logic               zero_vec;

  // Combinational helpers.
  logic signed [21:0] ts_s;
  logic signed [16:0] w_s;
  logic signed [17:0] aw_s;
  logic signed [15:0] rate_sel, tilt_a, tilt_b;
  logic signed [37:0] inc;
  logic signed [57:0] acc, acc_rnd;
  logic signed [39:0] yaw_wide;
  logic [33:0]        trial;
  logic signed [33:0] dx, dy;
  logic signed [32:0] z_rnd;
  logic signed [32:0] atan_v;

  assign ts_s     = signed'({1'b0, time_step});
  assign w_s      = signed'({1'b0, gyro_weight});
  assign aw_s     = signed'(18'h10000 - {2'b00, gyro_weight});
  assign rate_sel = last_rate[cmd.sel];
  assign inc      = (prod + (38'sd1 <<< (INC_SHIFT - 1))) >>> INC_SHIFT;
  assign acc      = 58'(pw) + 58'(pt);
  assign acc_rnd  = (acc + 58'sd32768) >>> 16;
  assign yaw_wide = 40'(yaw_sum) + 40'(inc);
  assign tilt_a   = cmd.sel[0] ? cur.accel_y : cur.accel_x;
  assign tilt_b   = cmd.sel[0] ? cur.accel_x : cur.accel_y;
  assign trial    = {1'b0, res} + {1'b0, rbit};
  assign dx       = cy >>> cmd.iter;
  assign dy       = cx >>> cmd.iter;
  assign atan_v   = atan_q24(cmd.iter);
  assign z_rnd    = (cz + (33'sd1 <<< (TILT_SHIFT - 1))) >>> TILT_SHIFT;

  // Configuration and filter state.
  always_ff @(posedge clk) begin
    if (rst) begin
      time_step    <= TIME_STEP_RESET;
      gyro_weight  <= GYRO_WEIGHT_RESET;
      fused[0]     <= '0;
      fused[1]     <= '0;
      last_tilt[0] <= '0;
      last_tilt[1] <= '0;
      last_rate[0] <= '0;
      last_rate[1] <= '0;
      last_rate[2] <= '0;
      yaw_sum      <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_TIME_STEP:   time_step   <= cfg_data[TS_W-1:0];
          REG_GYRO_WEIGHT: gyro_weight <= cfg_data[GW_W-1:0];
          default: ;
        endcase
      end
      if (cmd.op == OP_INC && cmd.sel == 2'd2) begin
        yaw_sum <= sat32(64'(yaw_wide));
      end
      if (cmd.op == OP_BR) begin
        fused[cmd.sel[0]] <= sat32(64'(acc_rnd));
      end
      if (cmd.op == OP_CEND) begin
        last_tilt[cmd.sel[0]] <= zero_vec ? 32'sd0 : z_rnd[31:0];
      end
      if (cmd.op == OP_OUT) begin
        last_rate[0] <= cur.rate_x;
        last_rate[1] <= cur.rate_y;
        last_rate[2] <= cur.rate_z;
      end
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: cur  <= in_data;
      OP_MUL:  prod <= rate_sel * ts_s;
      OP_INC:  sum  <= 40'(fused[cmd.sel[0]]) + 40'(inc);
      OP_BW:   pw   <= w_s * sum;
      OP_BT:   pt   <= aw_s * last_tilt[cmd.sel[0]];
      OP_SQ1:  sqb  <= tilt_b * tilt_b;
      OP_SQ2: begin
        rem  <= 33'(unsigned'(sqb))
              + 33'(unsigned'(32'(cur.accel_z) * 32'(cur.accel_z)));
        res  <= '0;
        rbit <= 33'h1_0000_0000;
      end
      OP_ROOT: begin
        if ({1'b0, rem} >= trial) begin
          rem <= rem - trial[32:0];
          res <= (res >> 1) + rbit;
        end else begin
          res <= res >> 1;
        end
        rbit <= rbit >> 2;
      end
      OP_CINIT: begin
        cx       <= signed'({1'b0, res}) <<< PRESCALE_SHIFT;
        cy       <= 34'(tilt_a) <<< PRESCALE_SHIFT;
        cz       <= '0;
        zero_vec <= (res == '0) && (tilt_a == 16'sd0);
      end
      OP_CORD: begin
        if (!cy[33]) begin
          cx <= cx + dx;
          cy <= cy - dy;
          cz <= cz + atan_v;
        end else begin
          cx <= cx - dx;
          cy <= cy + dy;
          cz <= cz - atan_v;
        end
      end
      OP_OUT: begin
        out_data.angle_x <= fused[0];
        out_data.angle_y <= fused[1];
        out_data.angle_z <= yaw_sum;
      end
      default: ;
    endcase
  end

endmodule

### tb/sv/complementary_tilt_filter_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// complementary_tilt_filter_tb
// Self-checking bench for the complementary tilt filter. Beats are fed from a
// queue through a valid/ready driver with random gaps, and every output beat
// is compared with a bit-exact predictor of the filter held in this bench.
// ----------------------------------------------------------------------------
module complementary_tilt_filter_tb;
  import ctf_pkg::*;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_we = 1'b0;
  logic             cfg_index = REG_TIME_STEP;
  logic [CFG_W-1:0] cfg_data = '0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  in_item_t         in_data = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_item_t        out_data;

  complementary_tilt_filter uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data)
  );

  always #1 clk = ~clk;

  // Predictor state, a private copy of the filter's registers.
  longint    step_reg, weight_reg;
  longint    ang_x, ang_y, yaw, prev_rx, prev_ry, prev_rz, prev_tx, prev_ty;
  longint    atan_lut [24] = '{
    754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
    15018523, 7509720, 3754917, 1877466, 938734, 469367,
    234684, 117342, 58671, 29335, 14668, 7334,
    3667, 1833, 917, 458, 229, 115};

  in_item_t  pending_beats [$];
  out_item_t expected_angles [$];
  int        send_idle_pct, recv_idle_pct;
  int        errors = 0;
  int        beats_checked = 0;
  longint    cycles = 0;

  // Adds half an LSB, then an arithmetic right shift floors toward minus infinity.
  function automatic longint round_sh(longint v, int n);
    if (n == 0) return v;
    return (v + (longint'(1) <<< (n - 1))) >>> n;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint root_of(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 32;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return longint'(res);
  endfunction

  // atan2(a, sqrt(b^2 + c^2)) in degrees by CORDIC vectoring.
  function automatic longint tilt_angle(longint a, longint b, longint c);
    longint mag, x, y, z, dx, dy;
    mag = root_of(longint'(b * b + c * c));
    z = 0;
    if (mag == 0 && a == 0) return 0;
    x = mag <<< PRESCALE_SHIFT;
    y = a <<< PRESCALE_SHIFT;
    for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += atan_lut[i];
      end else begin
        x -= dx; y += dy; z -= atan_lut[i];
      end
    end
    return round_sh(z, TILT_SHIFT);
  endfunction

  function automatic longint rate_increment(longint rate);
    return round_sh(rate * step_reg * (longint'(1) <<< ANGLE_FRAC_BITS), RATE_TIME_SHIFT);
  endfunction

  function automatic longint fuse(longint prev, longint rate, longint tilt);
    return clamp32(round_sh(weight_reg * (prev + rate_increment(rate))
                            + (65536 - weight_reg) * tilt, 16));
  endfunction

  // Advances the predictor by one accepted beat and queues the expected angles.
  task automatic predict_angles(in_item_t b);
    out_item_t o;
    ang_x = fuse(ang_x, prev_rx, prev_tx);
    ang_y = fuse(ang_y, prev_ry, prev_ty);
    yaw = clamp32(yaw + rate_increment(prev_rz));
    prev_rx = b.rate_x;
    prev_ry = b.rate_y;
    prev_rz = b.rate_z;
    prev_tx = tilt_angle(b.accel_x, b.accel_y, b.accel_z);
    prev_ty = tilt_angle(b.accel_y, b.accel_x, b.accel_z);
    o.angle_x = ang_x[31:0];
    o.angle_y = ang_y[31:0];
    o.angle_z = yaw[31:0];
    expected_angles.push_back(o);
  endtask

  // Driver: presents queued beats, holding valid and payload until accepted.
  // The handshake is judged on the values seen at this edge, so a beat that
  // is accepted now can be replaced by the next one in the same step.
  always @(posedge clk) begin
    if (!rst) begin
      if (!in_valid || in_ready) begin
        if (in_valid) predict_angles(in_data);
        if (pending_beats.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data <= pending_beats.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted result beat against the oldest expectation
  // and stalls the receiver at random.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_angles.size() == 0) begin
          $display("%0t: result beat with nothing expected: %h", $time, out_data);
          errors++;
        end else begin
          out_item_t e;
          e = expected_angles.pop_front();
          if (e.angle_x !== out_data.angle_x)
            $display("%0t: angle_x expected %0d got %0d", $time, e.angle_x, out_data.angle_x);
          if (e.angle_y !== out_data.angle_y)
            $display("%0t: angle_y expected %0d got %0d", $time, e.angle_y, out_data.angle_y);
          if (e.angle_z !== out_data.angle_z)
            $display("%0t: angle_z expected %0d got %0d", $time, e.angle_z, out_data.angle_z);
          if (e !== out_data) errors++;
          beats_checked++;
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Safety net against a hung handshake.
  always @(posedge clk) begin
    if (cycles > 64'd2000000) begin
      $display("timeout after %0d cycles", cycles);
      $display("complementary_tilt_filter_tb: errors");
      $finish;
    end
  end

  function automatic in_item_t random_beat();
    in_item_t b;
    b = {$urandom, $urandom, $urandom};
    // Mostly modest values so the fused angles move without saturating,
    // with full-range beats mixed in.
    if ($urandom_range(3) != 0) begin
      b.rate_x = $signed(16'($urandom_range(4000))) - 16'sd2000;
      b.rate_y = $signed(16'($urandom_range(4000))) - 16'sd2000;
      b.rate_z = $signed(16'($urandom_range(4000))) - 16'sd2000;
    end
    return b;
  endfunction

  task automatic write_reg(logic idx, longint val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_W'(val);
    if (idx == REG_TIME_STEP) step_reg = val;
    else weight_reg = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Waits until every queued beat went in and every result came back, then
  // lets the block's latency run out before anything else happens.
  task automatic drain();
    while (pending_beats.size() > 0 || in_valid || expected_angles.size() > 0)
      @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic run_phase(longint ts, longint gw, int n, int s_idle, int r_idle);
    write_reg(REG_TIME_STEP, ts);
    write_reg(REG_GYRO_WEIGHT, gw);
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    for (int i = 0; i < n; i++) pending_beats.push_back(random_beat());
    drain();
  endtask

  initial begin
    in_item_t d;
    step_reg = TIME_STEP_RESET;
    weight_reg = GYRO_WEIGHT_RESET;
    {ang_x, ang_y, yaw, prev_rx, prev_ry, prev_rz, prev_tx, prev_ty} = '0;
    send_idle_pct = 25;
    recv_idle_pct = 56;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed beats at reset settings: zero vector, zero root with both
    // signs of the tilt axis, full-scale corners and mixed extremes.
    d = '0;                                                        pending_beats.push_back(d);
    d = '{16'sd1000, 16'sd0, 16'sd0, 16'sd100, -16'sd100, 16'sd50}; pending_beats.push_back(d);
    d = '{-16'sd1000, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0};      pending_beats.push_back(d);
    d = '{16'sd0, 16'sd500, 16'sd0, 16'sd0, 16'sd0, 16'sd0};        pending_beats.push_back(d);
    d = '{16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd0, 16'sd0};      pending_beats.push_back(d);
    d = '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff};
    pending_beats.push_back(d);
    d = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000};
    pending_beats.push_back(d);
    d = '{16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff};
    pending_beats.push_back(d);
    d = '{16'sh7fff, 16'sh8000, 16'sh0001, 16'shffff, 16'sh0001, 16'sh8000};
    pending_beats.push_back(d);
    d = '{16'sh0000, 16'sh8000, 16'sh8000, 16'sd0, 16'sd0, 16'sd0};  pending_beats.push_back(d);
    d = '{-16'sd1, 16'sd0, 16'sd0, 16'sd1, 16'sd1, -16'sd1};         pending_beats.push_back(d);
    drain();

    // Zero time step and zero gyro weight: the accelerometer alone decides.
    run_phase(0, 0, 20, 25, 56);
    // Largest time step and weight with full-scale rates drive saturation.
    write_reg(REG_TIME_STEP, 21'h1fffff);
    write_reg(REG_GYRO_WEIGHT, 65535);
    for (int i = 0; i < 20; i++) begin
      d = random_beat();
      d.rate_x = 16'sh7fff; d.rate_y = 16'sh8000; d.rate_z = 16'sh7fff;
      pending_beats.push_back(d);
    end
    for (int i = 0; i < 20; i++) begin
      d = random_beat();
      d.rate_x = 16'sh8000; d.rate_y = 16'sh7fff; d.rate_z = 16'sh8000;
      pending_beats.push_back(d);
    end
    drain();

    // Random beats over several settings and all three idling patterns.
    run_phase(1049, 62259, 200, 25, 56);
    run_phase(1, 32768, 150, 56, 25);
    run_phase(1048576, 65535, 150, 56, 25);
    run_phase($urandom_range(2097151), $urandom_range(65535), 200, 0, 0);

    $display("checked %0d result beats over seven register settings,", beats_checked);
    $display("including zero and full-scale time step and gyro weight");
    if (errors == 0) begin
      $display("complementary_tilt_filter_tb: clean");
    end else begin
      $display("complementary_tilt_filter_tb: errors");
    end
    $finish;
  end

endmodule
